// File: hw/rtl/stdq_pkg.sv
// ----------------------------------------------------------------------------
// stdq_pkg
// Shared types and constants for the delta-list software timer queue.
// ----------------------------------------------------------------------------
package stdq_pkg;

	localparam int TIMERS = 16;
	localparam int ID_W   = 4;
	localparam int IW     = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int LW     = $clog2(TIMERS + 1);
	localparam int DW     = 32;
	localparam int EW     = 8;

	typedef logic [LW-1:0] link_t;
	localparam link_t NIL_LINK = LW'(TIMERS);

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_ONESHOT = 2'd1,
		REQ_REPEAT  = 2'd2,
		REQ_STOP    = 2'd3
	} req_t;

	// One timer record in the list memory
	typedef struct packed {
		logic [DW-1:0] delta;
		logic [DW-1:0] reload;
		logic [EW-1:0] evt;
		link_t         nxt;
		link_t         prv;
	} rec_t;

	typedef struct packed {
		logic delta;
		logic reload;
		logic evt;
		logic nxt;
		logic prv;
	} rec_en_t;

	// Write command from the sequencer to the record memory
	typedef struct packed {
		rec_en_t       en;
		logic [IW-1:0] addr;
		rec_t          data;
	} wr_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_U_RD,
		ST_U_RES,
		ST_U_NX,
		ST_U_PV,
		ST_S_CFG,
		ST_I_START,
		ST_I_CMP,
		ST_I_WT,
		ST_I_WC,
		ST_I_WP,
		ST_T_RD,
		ST_T_CHK,
		ST_T_EMIT,
		ST_T_END
	} state_t;

	function automatic logic lnk_ok(input link_t l);
		return l < LW'(TIMERS);
	endfunction

endpackage

// File: hw/rtl/stdq_if.sv
// ----------------------------------------------------------------------------
// stdq_in_if / stdq_out_if
// Valid/ready channels for timer requests and expiry reports.
// ----------------------------------------------------------------------------
interface stdq_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [3:0]  timer_id;
	logic [31:0] duration;
	logic [7:0]  event_id;

	modport source (output valid, req_type, timer_id, duration, event_id, input ready);
	modport sink (input valid, req_type, timer_id, duration, event_id, output ready);
endinterface

interface stdq_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] fired_timer;
	logic [7:0] fired_event;
	logic       last_fired;

	modport source (output valid, fired_timer, fired_event, last_fired, input ready);
	modport sink (input valid, fired_timer, fired_event, last_fired, output ready);
endinterface

// File: hw/rtl/software_timer_delta_queue_top.sv
// ----------------------------------------------------------------------------
// software_timer_delta_queue_top
// Bank of software timers kept as a delta list in a record memory.
//
//  channel  | dir | payload                                 | handshake
//  in_ch    | in  | req_type, timer_id, duration, event_id  | valid/ready
//  out_ch   | out | fired_timer, fired_event, last_fired    | valid/ready
//
// One request is processed at a time by a sequencer around a two-port
// record memory (one read and one write per cycle, registered read data).
// A start or stop first unlinks a queued timer; a start then walks the list.
// A tick decrements the head delta or reports and unlinks expired head entries;
// a repeating timer is reinserted with its reload value.
// Reset clears the list head and the queued flags; no clearing pass.
// A stalled output holds the sequencer only while an earlier report is pending.
// ----------------------------------------------------------------------------
module software_timer_delta_queue_top
	import stdq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	stdq_in_if.sink    in_ch,
	stdq_out_if.source out_ch
);

	state_t state_q, state_d;

	logic          tick_q;
	req_t          req_q;
	logic [DW-1:0] dur_q;
	logic [EW-1:0] ev_q;
	link_t         tgt_q;
	rec_t          urec_q;
	logic [DW-1:0] reload_q;
	logic [DW-1:0] d_q;
	link_t         cur_q;
	link_t         prv_q;
	logic [DW-1:0] cdelta_q;
	link_t         head_q;
	logic [TIMERS-1:0] queued_q;
	logic          pend_valid_q;
	logic [ID_W-1:0] pend_timer_q;
	logic [EW-1:0] pend_ev_q;
	logic [EW-1:0] fev_q;
	logic          out_valid_q;
	logic [ID_W-1:0] out_timer_q;
	logic [EW-1:0] out_ev_q;
	logic          out_last_q;

	wr_t           wr;
	logic [IW-1:0] raddr;
	rec_t          rd;
	logic          accept;
	logic          slot_free;
	logic          push;
	logic          push_last;
	link_t         id_link;

	stdq_rec_mem u_mem (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rd)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign slot_free   = !out_valid_q || out_ch.ready;
	assign id_link     = LW'(in_ch.timer_id);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_t'(in_ch.req_type) == REQ_TICK) state_d = ST_T_RD;
					else if (id_link < LW'(TIMERS) && queued_q[id_link[IW-1:0]])
						state_d = ST_U_RD;
					else state_d = ST_S_CFG;
				end
			end
			ST_U_RD:  state_d = ST_U_RES;
			ST_U_RES: state_d = lnk_ok(rd.nxt) ? ST_U_NX : ST_U_PV;
			ST_U_NX:  state_d = ST_U_PV;
			ST_U_PV: begin
				if (!tick_q) state_d = ST_S_CFG;
				else if (reload_q != '0) state_d = ST_I_START;
				else state_d = ST_T_RD;
			end
			ST_S_CFG: begin
				if (req_q == REQ_STOP || dur_q == '0 || !(tgt_q < LW'(TIMERS)))
					state_d = ST_IDLE;
				else state_d = ST_I_START;
			end
			ST_I_START: state_d = lnk_ok(head_q) ? ST_I_CMP : ST_I_WT;
			ST_I_CMP: begin
				if (d_q < rd.delta || !lnk_ok(rd.nxt)) state_d = ST_I_WT;
			end
			ST_I_WT: state_d = ST_I_WC;
			ST_I_WC: state_d = ST_I_WP;
			ST_I_WP: state_d = tick_q ? ST_T_RD : ST_IDLE;
			ST_T_RD: state_d = lnk_ok(head_q) ? ST_T_CHK : ST_T_END;
			ST_T_CHK: state_d = (rd.delta != '0) ? ST_T_END : ST_T_EMIT;
			ST_T_EMIT: begin
				if (!pend_valid_q || slot_free)
					state_d = lnk_ok(urec_q.nxt) ? ST_U_NX : ST_U_PV;
			end
			ST_T_END: begin
				if (!pend_valid_q || slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory accesses and output pushes
	always_comb begin
		wr        = '0;
		raddr     = '0;
		push      = 1'b0;
		push_last = 1'b0;
		case (state_q)
			ST_U_RD: raddr = tgt_q[IW-1:0];
			ST_U_RES: raddr = rd.nxt[IW-1:0];
			ST_U_NX: begin
				wr.en.delta    = 1'b1;
				wr.en.prv      = 1'b1;
				wr.addr        = urec_q.nxt[IW-1:0];
				wr.data.delta  = rd.delta + urec_q.delta;
				wr.data.prv    = urec_q.prv;
			end
			ST_U_PV: begin
				if (lnk_ok(urec_q.prv)) begin
					wr.en.nxt   = 1'b1;
					wr.addr     = urec_q.prv[IW-1:0];
					wr.data.nxt = urec_q.nxt;
				end
			end
			ST_S_CFG: begin
				if (state_d == ST_I_START) begin
					wr.en.evt      = 1'b1;
					wr.en.reload   = 1'b1;
					wr.addr        = tgt_q[IW-1:0];
					wr.data.evt    = ev_q;
					wr.data.reload = (req_q == REQ_REPEAT) ? dur_q : '0;
				end
			end
			ST_I_START: raddr = head_q[IW-1:0];
			ST_I_CMP: raddr = rd.nxt[IW-1:0];
			ST_I_WT: begin
				wr.en.delta   = 1'b1;
				wr.en.nxt     = 1'b1;
				wr.en.prv     = 1'b1;
				wr.addr       = tgt_q[IW-1:0];
				wr.data.delta = d_q;
				wr.data.nxt   = cur_q;
				wr.data.prv   = prv_q;
			end
			ST_I_WC: begin
				if (lnk_ok(cur_q)) begin
					wr.en.delta   = 1'b1;
					wr.en.prv     = 1'b1;
					wr.addr       = cur_q[IW-1:0];
					wr.data.delta = cdelta_q - d_q;
					wr.data.prv   = tgt_q;
				end
			end
			ST_I_WP: begin
				if (lnk_ok(prv_q)) begin
					wr.en.nxt   = 1'b1;
					wr.addr     = prv_q[IW-1:0];
					wr.data.nxt = tgt_q;
				end
			end
			ST_T_RD: raddr = head_q[IW-1:0];
			ST_T_CHK: begin
				if (rd.delta != '0) begin
					wr.en.delta   = 1'b1;
					wr.addr       = head_q[IW-1:0];
					wr.data.delta = rd.delta - 1'b1;
				end
			end
			ST_T_EMIT: begin
				raddr = urec_q.nxt[IW-1:0];
				push  = pend_valid_q && slot_free;
			end
			ST_T_END: begin
				push      = pend_valid_q && slot_free;
				push_last = 1'b1;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= NIL_LINK;
			queued_q     <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_U_PV) begin
				queued_q[tgt_q[IW-1:0]] <= 1'b0;
				if (!lnk_ok(urec_q.prv)) head_q <= urec_q.nxt;
			end
			if (state_q == ST_I_WP) begin
				queued_q[tgt_q[IW-1:0]] <= 1'b1;
				if (!lnk_ok(prv_q)) head_q <= tgt_q;
			end
			if (state_q == ST_T_EMIT && state_d != ST_T_EMIT) pend_valid_q <= 1'b1;
			if (state_q == ST_T_END && state_d == ST_IDLE) pend_valid_q <= 1'b0;
			if (push) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			tick_q <= (req_t'(in_ch.req_type) == REQ_TICK);
			req_q  <= req_t'(in_ch.req_type);
			dur_q  <= in_ch.duration;
			ev_q   <= in_ch.event_id;
			tgt_q  <= id_link;
		end
		case (state_q)
			ST_U_RES: urec_q <= rd;
			ST_U_PV:  d_q    <= reload_q;
			ST_S_CFG: d_q    <= dur_q;
			ST_I_START: begin
				cur_q <= head_q;
				prv_q <= NIL_LINK;
			end
			ST_I_CMP: begin
				if (d_q < rd.delta) begin
					cdelta_q <= rd.delta;
				end else begin
					d_q   <= d_q - rd.delta;
					prv_q <= cur_q;
					cur_q <= rd.nxt;
				end
			end
			ST_T_CHK: begin
				tgt_q    <= head_q;
				urec_q   <= rd;
				reload_q <= rd.reload;
				fev_q    <= rd.evt;
			end
			ST_T_EMIT: begin
				if (state_d != ST_T_EMIT) begin
					pend_timer_q <= tgt_q[ID_W-1:0];
					pend_ev_q    <= fev_q;
				end
			end
			default: ;
		endcase
		if (push) begin
			out_timer_q <= pend_timer_q;
			out_ev_q    <= pend_ev_q;
			out_last_q  <= push_last;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.fired_timer = out_timer_q;
	assign out_ch.fired_event = out_ev_q;
	assign out_ch.last_fired  = out_last_q;

endmodule

// File: hw/rtl/stdq_rec_mem.sv
// ----------------------------------------------------------------------------
// stdq_rec_mem
// Timer record memory: one write port with per-field enables, one read
// port with registered data.
// ----------------------------------------------------------------------------
module stdq_rec_mem
	import stdq_pkg::*;
(
	input  logic          clk,
	input  wr_t           wr,
	input  logic [IW-1:0] raddr,
	output rec_t          rdata
);

	rec_t mem [TIMERS];

	// Write the enabled fields
	always_ff @(posedge clk) begin
		if (wr.en.delta)  mem[wr.addr].delta  <= wr.data.delta;
		if (wr.en.reload) mem[wr.addr].reload <= wr.data.reload;
		if (wr.en.evt)    mem[wr.addr].evt    <= wr.data.evt;
		if (wr.en.nxt)    mem[wr.addr].nxt    <= wr.data.nxt;
		if (wr.en.prv)    mem[wr.addr].prv    <= wr.data.prv;
	end

	// Register read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/stdq_checker.sv
// ----------------------------------------------------------------------------
// stdq_checker
// Port-level checks for the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module stdq_checker
	import stdq_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] fired_timer,
	input logic [7:0] fired_event,
	input logic       last_fired
);

	// Hold a stalled expiry report
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fired_timer)
			&& $stable(fired_event) && $stable(last_fired))
		else $error("stalled expiry report changed");

	// Stay busy while a tick has more expiries to report
	a_mid_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_fired |-> !in_ready)
		else $error("request taken in the middle of a tick");

	// Drop ready in the cycle after each accepted request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken on consecutive cycles");

endmodule

bind software_timer_delta_queue_top stdq_checker u_stdq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.fired_timer (out_ch.fired_timer),
	.fired_event (out_ch.fired_event),
	.last_fired  (out_ch.last_fired)
);
